// ----- hdl/apc_pkg.sv -----
// ----------------------------------------------------------------------------
// apc_pkg
// Types, codes and tables shared by the pulse channel modules.
// ----------------------------------------------------------------------------
package apc_pkg;

  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 4;

  // Channel one subtracts one extra step on a negated sweep
  localparam logic ChannelOne = 1'b1;

  localparam logic [11:0] MuteHigh = 12'h7FF;
  localparam logic [11:0] MuteLow = 12'd8;
  localparam logic [3:0] DecayTop = 4'd15;
  localparam logic [11:0] PeriodMax = 12'hFFF;

  typedef enum logic [1:0] {
    MODE_TICK    = 2'd0,
    MODE_QUARTER = 2'd1,
    MODE_HALF    = 2'd2,
    MODE_RESTART = 2'd3
  } mode_t;

  localparam logic [CfgIdxW-1:0] REG_DUTY       = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_VOLUME     = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_CONST_VOL  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_LOOP_HALT  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_SWEEP_EN   = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_SWEEP_PER  = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_SWEEP_NEG  = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_SWEEP_SHFT = 3'd7;

  typedef struct packed {
    logic [1:0] duty;
    logic [3:0] volume;
    logic       fixed_vol;
    logic       loop_halt;
    logic       sweep_enable;
    logic [2:0] sweep_period;
    logic       sweep_negate;
    logic [2:0] sweep_shift;
  } cfg_t;

  function automatic logic duty_bit(input logic [1:0] sel, input logic [2:0] step);
    logic [7:0] row;
    case (sel)
      2'd0: row = 8'b0000_0010;
      2'd1: row = 8'b0000_0110;
      2'd2: row = 8'b0001_1110;
      2'd3: row = 8'b1111_1001;
      default: row = 8'b0000_0000;
    endcase
    return row[step];
  endfunction

endpackage

// ----- hdl/apc_cfg.sv -----
// ----------------------------------------------------------------------------
// apc_cfg
// Configuration register file, written one field per transaction.
// ----------------------------------------------------------------------------
module apc_cfg import apc_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  logic [CfgIdxW-1:0]  wr_index,
  input  logic [CfgDataW-1:0] wr_data,
  output cfg_t                cfg
);

  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        REG_DUTY:       cfg_nxt.duty = wr_data[1:0];
        REG_VOLUME:     cfg_nxt.volume = wr_data;
        REG_CONST_VOL:  cfg_nxt.fixed_vol = wr_data[0];
        REG_LOOP_HALT:  cfg_nxt.loop_halt = wr_data[0];
        REG_SWEEP_EN:   cfg_nxt.sweep_enable = wr_data[0];
        REG_SWEEP_PER:  cfg_nxt.sweep_period = wr_data[2:0];
        REG_SWEEP_NEG:  cfg_nxt.sweep_negate = wr_data[0];
        REG_SWEEP_SHFT: cfg_nxt.sweep_shift = wr_data[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- hdl/apc_core.sv -----
// ----------------------------------------------------------------------------
// apc_core
// Channel state (timer, duty, sweep, envelope, length) and sample generation.
// ----------------------------------------------------------------------------
module apc_core import apc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  mode_t       mode,
  input  logic [10:0] period_value,
  input  logic [7:0]  length_value,
  input  logic        channel_on,
  input  cfg_t        cfg,
  output logic [3:0]  sample_nxt
);

  logic [11:0] timer_count_r, timer_count_nxt;
  logic [11:0] timer_period_r, timer_period_nxt;
  logic [2:0]  duty_step_r, duty_step_nxt;
  logic [3:0]  sweep_count_r, sweep_count_nxt;
  logic        sweep_rld_r, sweep_rld_nxt;
  logic        envelope_start_r, envelope_start_nxt;
  logic [3:0]  envelope_count_r, envelope_count_nxt;
  logic [3:0]  env_level_r, env_level_nxt;
  logic [7:0]  length_count_r, length_count_nxt;

  logic [11:0] timer_dec;
  logic [11:0] delta;
  logic [12:0] sum;
  logic [12:0] sub;
  logic [11:0] swept;
  logic        muted;

  assign timer_dec = timer_count_r - 12'd1;
  assign delta = timer_period_r >> cfg.sweep_shift;
  assign sum = {1'b0, timer_period_r} + {1'b0, delta};
  assign sub = {1'b0, delta} + {12'd0, ChannelOne};

  always_comb begin
    if (cfg.sweep_negate) begin
      swept = (sub >= {1'b0, timer_period_r}) ? 12'd0 : timer_period_r - sub[11:0];
    end else begin
      swept = sum[12] ? PeriodMax : sum[11:0];
    end
  end

  always_comb begin
    timer_count_nxt = timer_count_r;
    timer_period_nxt = timer_period_r;
    duty_step_nxt = duty_step_r;
    sweep_count_nxt = sweep_count_r;
    sweep_rld_nxt = sweep_rld_r;
    envelope_start_nxt = envelope_start_r;
    envelope_count_nxt = envelope_count_r;
    env_level_nxt = env_level_r;
    length_count_nxt = length_count_r;
    if (go) begin
      case (mode)
        MODE_TICK: begin
          if (timer_dec == 12'd0) begin
            timer_count_nxt = timer_period_r;
            duty_step_nxt = duty_step_r + 3'd1;
          end else begin
            timer_count_nxt = timer_dec;
          end
        end
        MODE_QUARTER: begin
          if (envelope_start_r) begin
            envelope_start_nxt = 1'b0;
            env_level_nxt = DecayTop;
            envelope_count_nxt = cfg.volume;
          end else if (envelope_count_r != 4'd0) begin
            envelope_count_nxt = envelope_count_r - 4'd1;
          end else begin
            envelope_count_nxt = cfg.volume;
            if (env_level_r != 4'd0) begin
              env_level_nxt = env_level_r - 4'd1;
            end else if (cfg.loop_halt) begin
              env_level_nxt = DecayTop;
            end
          end
        end
        MODE_HALF: begin
          if (!cfg.loop_halt && length_count_r != 8'd0) begin
            length_count_nxt = length_count_r - 8'd1;
          end
          if (sweep_rld_r) begin
            sweep_count_nxt = {1'b0, cfg.sweep_period} + 4'd1;
            sweep_rld_nxt = 1'b0;
          end else if (sweep_count_r != 4'd0) begin
            sweep_count_nxt = sweep_count_r - 4'd1;
          end else begin
            sweep_count_nxt = {1'b0, cfg.sweep_period} + 4'd1;
            if (cfg.sweep_enable) begin
              timer_period_nxt = swept;
            end
          end
        end
        MODE_RESTART: begin
          timer_period_nxt = {1'b0, period_value};
          length_count_nxt = length_value;
          envelope_start_nxt = 1'b1;
          sweep_rld_nxt = 1'b1;
          duty_step_nxt = 3'd0;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    muted = (timer_period_nxt < MuteLow) || (timer_period_nxt > MuteHigh);
    if (!channel_on || !duty_bit(cfg.duty, duty_step_nxt) || muted ||
        length_count_nxt == 8'd0) begin
      sample_nxt = 4'd0;
    end else begin
      sample_nxt = cfg.fixed_vol ? cfg.volume : env_level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timer_count_r <= '0;
      timer_period_r <= '0;
      duty_step_r <= '0;
      sweep_count_r <= '0;
      sweep_rld_r <= 1'b0;
      envelope_start_r <= 1'b0;
      envelope_count_r <= '0;
      env_level_r <= '0;
      length_count_r <= '0;
    end else begin
      timer_count_r <= timer_count_nxt;
      timer_period_r <= timer_period_nxt;
      duty_step_r <= duty_step_nxt;
      sweep_count_r <= sweep_count_nxt;
      sweep_rld_r <= sweep_rld_nxt;
      envelope_start_r <= envelope_start_nxt;
      envelope_count_r <= envelope_count_nxt;
      env_level_r <= env_level_nxt;
      length_count_r <= length_count_nxt;
    end
  end

  a_restart_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (go && mode == MODE_RESTART) |=>
      (duty_step_r == 3'd0 && envelope_start_r && sweep_rld_r))
    else $error("restart did not set flags and clear duty step");

  a_length_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (go && mode == MODE_HALF && !cfg.loop_halt && length_count_r != 8'd0) |=>
      (length_count_r == $past(length_count_r) - 8'd1))
    else $error("length counter did not decrement on half frame");

  a_silent_len: assert property (@(posedge clk) disable iff (!rst_n)
    (sample_nxt != 4'd0) |-> (length_count_nxt != 8'd0 && channel_on))
    else $error("sample not gated by length or enable");

  a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !go |=> ($stable(timer_count_r) && $stable(timer_period_r) && $stable(length_count_r)))
    else $error("channel state changed without a transaction");

endmodule

// ----- hdl/apu_pulse_channel.sv -----
// ----------------------------------------------------------------------------
// apu_pulse_channel
// Pulse (square-wave) sound channel: one event in, one 4-bit sample out.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_stall carry one event (tick, quarter frame,
// half frame, restart) with the restart period, length and channel enable.
// Output channel: out_valid/out_stall carry the sample after that event.
// Configuration: cfg_valid/cfg_ready write one register by index; cfg_ready
// is always high. Write only while no transaction is in flight.
// An accepted event sits in the input register; its sample is registered
// into the output register once the output can advance (out_valid low or
// out_stall low), and out_valid rises with it.
// Throughput: one event per cycle when not stalled; the state update is one
// pass of combinational logic, so each event sees the state the last one left.
// Reset (rst_n low, synchronous) clears the configuration registers, the
// channel state and the valid flags. When out_stall is high with a sample
// waiting, the event held in the input register waits and in_stall rises;
// nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module apu_pulse_channel import apc_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_mode,
  input  logic [10:0]         in_period_value,
  input  logic [7:0]          in_length_value,
  input  logic                in_channel_on,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [3:0]          out_sample,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  cfg_t        cfg;
  logic        s1_valid_r;
  mode_t       s1_mode_r;
  logic [10:0] s1_period_r;
  logic [7:0]  s1_length_r;
  logic        s1_on_r;
  logic        out_valid_r;
  logic [3:0]  out_sample_r;
  logic [3:0]  sample_nxt;
  logic        advance;
  logic        go;

  assign cfg_ready = 1'b1;
  assign advance = !out_valid_r || !out_stall;
  assign go = s1_valid_r && advance;
  assign in_stall = s1_valid_r && !advance;

  apc_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  apc_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .go           (go),
    .mode         (s1_mode_r),
    .period_value (s1_period_r),
    .length_value (s1_length_r),
    .channel_on   (s1_on_r),
    .cfg          (cfg),
    .sample_nxt   (sample_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_mode_r <= mode_t'(in_mode);
      s1_period_r <= in_period_value;
      s1_length_r <= in_length_value;
      s1_on_r <= in_channel_on;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      out_sample_r <= sample_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_sample = out_sample_r;

endmodule
